// File: design/tccs_pkg.sv
package tccs_pkg;

    // opcode values
    localparam logic [0:0] OP_PUT  = 1'b0;
    localparam logic [0:0] OP_READ = 1'b1;

    // control bytes
    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    typedef struct packed {
        logic [0:0] opcode;
        logic [7:0] char_code;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic [5:0] cursor_row;
        logic [6:0] cursor_col;
        logic       scrolled;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic clear;
        logic scroll;
        logic emit;
        logic load_out;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;
        logic need_scroll;
        logic out_free;
    } t_ctl_stat;

endpackage

// File: design/text_console_cursor_scroll_unit.sv
// Put and read words reach the output register in the emit state that follows
// accept; emit waits while the register is still full. A line feed or wrap on
// the bottom row first runs a scroll sweep and a drain state. A new word is
// taken only in idle; the scroll copy is bound by the single write port of the
// cell RAM, one cell per cycle. Reset (sync, active low): cursor to 0,0; then a
// clearing pass zeroes all ROWS*COLS cells; no input word is taken until it completes.
module text_console_cursor_scroll_unit
    import tccs_pkg::*;
#(
    parameter int ROWS = 60,
    parameter int COLS = 80
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // Controller sequences clear, accept, scroll sweep, drain and emit;
    // the datapath holds the cursor, the cell RAM and the output register.
    t_ctl_cmd  cmd;
    t_ctl_stat stat;

    tccs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Output register parts the sides: a new word is taken while the
    // previous result still waits; emit stalls only when it is still full.
    tccs_dpath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    assign o_in_ready = cmd.in_ready;

endmodule

// File: design/tccs_ram.sv
module tccs_ram
    import tccs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4800
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tccs_ctrl.sv
module tccs_ctrl
    import tccs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_ctl_stat i_stat,
    output t_ctl_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCROLL = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_stat.need_scroll ? ST_SCROLL : ST_EMIT;
                end
            end
            ST_SCROLL: begin
                o_cmd.scroll = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.load_out = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

`ifndef SYNTH
    // a scroll sweep stays in scroll until its last cell, then hands over to the drain state, never to emit
    a_scroll_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL && !i_stat.sweep_last) |=> (r_state == ST_SCROLL))
        else $error("scroll sweep left early");
`endif

endmodule

// File: design/tccs_dpath.sv
module tccs_dpath
    import tccs_pkg::*;
#(
    parameter int ROWS = 60,
    parameter int COLS = 80
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl_cmd  i_cmd,
    output t_ctl_stat o_stat,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int N  = ROWS * COLS;
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int AW = $clog2(N);

    // cursor
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] col_pos;

    // sweep (clear and scroll)
    logic [AW-1:0] r_idx;
    logic          r_cp_pend;
    logic [AW-1:0] r_cp_addr;
    logic          r_cp_zero;

    // pending character write and result bits
    logic          r_char_pend;
    logic [7:0]    r_char;
    logic [AW-1:0] r_char_addr;
    logic          r_use_rd;
    logic          r_scr;

    logic          r_out_valid;
    t_out_word     r_out;

    logic is_put, is_cr, is_lf, printable, wrap, step_row, at_bottom, need_scroll;
    logic rd_in_range;
    logic sweep_last;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    always_comb begin
        is_put    = (i_in_word.opcode == OP_PUT);
        is_cr     = (i_in_word.char_code == CHAR_CR);
        is_lf     = (i_in_word.char_code == CHAR_LF);
        printable = !is_cr && !is_lf;
        wrap      = (r_col >= COLS - 1);
        step_row  = is_lf || (printable && wrap);
        at_bottom = (r_row >= ROWS - 1);
        n_row     = r_row;
        n_col     = r_col;
        col_pos   = r_col;
        if (is_put) begin
            if (!printable) begin
                n_col = '0;
            end else begin
                if (wrap) begin
                    col_pos = '0;
                end
                n_col = col_pos + 1'b1;
            end
            if (step_row && !at_bottom) begin
                n_row = r_row + 1'b1;
            end
        end
        need_scroll = is_put && step_row && at_bottom;
        rd_in_range = (i_in_word.read_row < ROWS) && (i_in_word.read_col < COLS);
        sweep_last  = (r_idx == AW'(N - 1));
    end

    // write port: clear sweep, copy pipeline, then the held character
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_char_addr;
        ram_wdata = r_char;
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx;
            ram_wdata = '0;
        end else if (r_cp_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_addr;
            ram_wdata = r_cp_zero ? 8'h00 : ram_rdata;
        end else if (i_cmd.emit && r_char_pend) begin
            ram_we    = 1'b1;
        end
    end

    // read port: row below during scroll, or the requested cell
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = AW'(i_in_word.read_row * COLS + i_in_word.read_col);
        if (i_cmd.scroll) begin
            ram_re    = (r_idx < N - COLS);
            ram_raddr = AW'(r_idx + COLS);
        end else if (i_cmd.accept && !is_put && rd_in_range) begin
            ram_re    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_cp_pend   <= 1'b0;
            r_char_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_row       <= n_row;
                r_col       <= n_col;
                r_char_pend <= is_put && printable;
            end
            if (i_cmd.clear || i_cmd.scroll) begin
                r_idx <= sweep_last ? '0 : r_idx + 1'b1;
            end
            r_cp_pend <= i_cmd.scroll;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_idx;
        r_cp_zero <= (r_idx >= N - COLS);
        if (i_cmd.accept) begin
            r_char      <= i_in_word.char_code;
            r_char_addr <= AW'(n_row * COLS + col_pos);
            r_use_rd    <= !is_put && rd_in_range;
            r_scr       <= need_scroll;
        end
        if (i_cmd.load_out) begin
            r_out.read_data  <= r_use_rd ? ram_rdata : 8'h00;
            r_out.cursor_row <= 6'(r_row);
            r_out.cursor_col <= 7'(r_col);
            r_out.scrolled   <= r_scr;
        end
    end

    tccs_ram #(
        .WIDTH (8),
        .DEPTH (N)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.sweep_last  = sweep_last;
    assign o_stat.need_scroll = need_scroll;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_word         = r_out;

`ifndef SYNTH
    // copy writes never collide with the clearing pass
    a_clear_no_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> !r_cp_pend)
        else $error("copy write during clear");

    // last copy write drains before the character write
    a_copy_before_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_pend |-> !i_cmd.emit)
        else $error("copy write overlaps emit");

    // scrolling only happens with the cursor on the bottom row
    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scroll |-> (r_row == RW'(ROWS - 1)))
        else $error("scroll with cursor off bottom row");

    // cursor column stays within the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_col < COLS))
        else $error("cursor column out of range");
`endif

endmodule
